/* design/cvlr_pkg.sv */
// ----------------------------------------------------------------------------
// cvlr_pkg
// Shared widths, reset values, register indexes and beat types of the 3x3
// convolution accumulator with leaky ReLU and int8 requantisation.
// ----------------------------------------------------------------------------
`default_nettype none

package cvlr_pkg;

    // Default geometry, handed to the top level parameters.
    localparam int FILTERS_DEF   = 4;
    localparam int POSITIONS_DEF = 256;
    localparam int CHANNELS_DEF  = 3;

    // Fixed field widths of the beats.
    localparam int TAPS   = 9;
    localparam int PIX_W  = 8;
    localparam int BYTE_W = 8;
    localparam int FILT_W = 2;
    localparam int POS_W  = 8;
    localparam int CHAN_W = 2;

    // Arithmetic widths.
    localparam int PROD_W     = 16;
    localparam int DOT_W      = 20;
    localparam int SUM_W      = 16;
    localparam int LEAK_W     = 9;
    localparam int LEAK_SHIFT = 9;
    localparam int BIAS_W     = 16;
    localparam int MULT_W     = 16;
    localparam int REQ_SHIFT  = 16;

    // Configuration registers.
    localparam int WREG_W    = 64;
    localparam int WREGS     = 5;
    localparam int WFLAT_W   = WREG_W * WREGS;
    localparam int CFG_IDX_W = 4;

    localparam logic [LEAK_W-1:0]        LEAK_RST = 9'd51;
    localparam logic signed [BIAS_W-1:0] BIAS_RST = 16'sd14745;
    localparam logic [MULT_W-1:0]        MULT_RST = 16'd155;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WEIGHTS_A    = 4'd0,
        REG_WEIGHTS_B    = 4'd1,
        REG_WEIGHTS_C    = 4'd2,
        REG_WEIGHTS_D    = 4'd3,
        REG_WEIGHTS_E    = 4'd4,
        REG_LEAK_MULT    = 4'd5,
        REG_REQUANT_BIAS = 4'd6,
        REG_REQUANT_MULT = 4'd7
    } reg_idx_t;

    // Input window beat.
    typedef struct packed {
        logic signed [PIX_W-1:0] pix_0;
        logic signed [PIX_W-1:0] pix_1;
        logic signed [PIX_W-1:0] pix_2;
        logic signed [PIX_W-1:0] pix_3;
        logic signed [PIX_W-1:0] pix_4;
        logic signed [PIX_W-1:0] pix_5;
        logic signed [PIX_W-1:0] pix_6;
        logic signed [PIX_W-1:0] pix_7;
        logic signed [PIX_W-1:0] pix_8;
        logic [FILT_W-1:0]       filter;
        logic [POS_W-1:0]        position;
        logic [CHAN_W-1:0]       channel;
    } win_t;

    // Result beat.
    typedef struct packed {
        logic [FILT_W-1:0] out_filter;
        logic [POS_W-1:0]  out_position;
        logic [BYTE_W-1:0] out_byte;
    } res_t;

    // Configuration write beat.
    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [WREG_W-1:0]    value;
    } cfg_t;

    // Control that travels down the pipeline with each item.
    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last;
        logic [FILT_W-1:0] filt;
        logic [POS_W-1:0]  pos;
    } tag_t;

endpackage

`default_nettype wire

/* design/cvlr_if.sv */
// ----------------------------------------------------------------------------
// cvlr_stream_if
// Valid/ready channel carrying one payload beat of a chosen type.
// ----------------------------------------------------------------------------
`default_nettype none

interface cvlr_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/cvlr_mac.sv */
// ----------------------------------------------------------------------------
// cvlr_mac
// Window capture, nine weight-by-pixel products and their sum, three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module cvlr_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  cvlr_pkg::tag_t                      tag_i,
    input  cvlr_pkg::win_t                      win_i,
    input  logic [cvlr_pkg::WFLAT_W-1:0]        weights,
    output cvlr_pkg::tag_t                      tag_o,
    output logic signed [cvlr_pkg::DOT_W-1:0]   dot_o
);

    localparam int TAPS   = cvlr_pkg::TAPS;
    localparam int PIX_W  = cvlr_pkg::PIX_W;
    localparam int BYTE_W = cvlr_pkg::BYTE_W;
    localparam int PROD_W = cvlr_pkg::PROD_W;
    localparam int DOT_W  = cvlr_pkg::DOT_W;

    cvlr_pkg::tag_t tag1_reg, tag2_reg, tag3_reg;
    logic signed [PIX_W-1:0]  pix1_reg [TAPS];
    logic signed [PIX_W-1:0]  pix_in   [TAPS];
    logic signed [BYTE_W-1:0] wsel     [TAPS];
    logic signed [PROD_W-1:0] prod_next [TAPS];
    logic signed [PROD_W-1:0] prod2_reg [TAPS];
    logic signed [DOT_W-1:0]  dot_next;
    logic signed [DOT_W-1:0]  dot3_reg;

    // Window pixels in tap order, row by row.
    assign pix_in[0] = win_i.pix_0;
    assign pix_in[1] = win_i.pix_1;
    assign pix_in[2] = win_i.pix_2;
    assign pix_in[3] = win_i.pix_3;
    assign pix_in[4] = win_i.pix_4;
    assign pix_in[5] = win_i.pix_5;
    assign pix_in[6] = win_i.pix_6;
    assign pix_in[7] = win_i.pix_7;
    assign pix_in[8] = win_i.pix_8;

    // Control travels with the data; the whole pipeline holds on a stall.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else if (adv)
        begin
            tag1_reg <= tag_i;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    // Weight bytes of the item's filter: flat index filter*9+tap.
    always_comb
    begin
        for (int t = 0; t < TAPS; t++)
        begin
            wsel[t]      = weights[(int'(tag1_reg.filt) * TAPS + t) * BYTE_W +: BYTE_W];
            prod_next[t] = wsel[t] * pix1_reg[t];
        end
    end

    // Sum of the nine registered products.
    always_comb
    begin
        dot_next = '0;
        for (int t = 0; t < TAPS; t++)
        begin
            dot_next = dot_next + DOT_W'(prod2_reg[t]);
        end
    end

    // Payload stages.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int t = 0; t < TAPS; t++)
            begin
                pix1_reg[t]  <= pix_in[t];
                prod2_reg[t] <= prod_next[t];
            end
            dot3_reg <= dot_next;
        end
    end

    assign tag_o = tag3_reg;
    assign dot_o = dot3_reg;

endmodule

`default_nettype wire

/* design/cvlr_psum.sv */
// ----------------------------------------------------------------------------
// cvlr_psum
// Partial-sum memory with read-modify-write, forwarding and 16-bit clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module cvlr_psum #(
    parameter int FILTERS   = cvlr_pkg::FILTERS_DEF,
    parameter int POSITIONS = cvlr_pkg::POSITIONS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               adv,
    input  cvlr_pkg::tag_t                     rd_tag,
    input  cvlr_pkg::tag_t                     tag3,
    input  logic signed [cvlr_pkg::DOT_W-1:0]  dot3,
    output cvlr_pkg::tag_t                     tag4_o,
    output logic signed [cvlr_pkg::SUM_W-1:0]  sum4_o
);

    localparam int DEPTH = FILTERS * POSITIONS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W = cvlr_pkg::SUM_W;
    localparam int DOT_W = cvlr_pkg::DOT_W;
    localparam int ACC_W = DOT_W + 1;

    localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_W'(32768);

    function automatic logic [AW-1:0] entry_addr(
        input logic [cvlr_pkg::FILT_W-1:0] filt,
        input logic [cvlr_pkg::POS_W-1:0]  pos
    );
        return AW'(int'(filt) * POSITIONS + int'(pos));
    endfunction

    logic signed [SUM_W-1:0] mem [DEPTH];

    logic signed [SUM_W-1:0] rdata1_reg, rdata2_reg, rdata3_reg;
    logic [AW-1:0]           rd_addr, addr3;
    logic signed [SUM_W-1:0] base;
    logic signed [ACC_W-1:0] acc;
    logic signed [SUM_W-1:0] sum_next;

    // Copies of the last three writes, aligned with the stages after the write.
    cvlr_pkg::tag_t          tag4_reg;
    logic                    w5_valid_reg, w6_valid_reg;
    logic [AW-1:0]           w4_addr_reg, w5_addr_reg, w6_addr_reg;
    logic signed [SUM_W-1:0] w4_sum_reg, w5_sum_reg, w6_sum_reg;

    assign rd_addr = entry_addr(rd_tag.filt, rd_tag.pos);
    assign addr3   = entry_addr(tag3.filt, tag3.pos);

    // Stored sum with the newest pending write to the same entry taking
    // priority; the first channel starts from zero.
    always_comb
    begin
        base = rdata3_reg;
        if (w6_valid_reg && (w6_addr_reg == addr3))
        begin
            base = w6_sum_reg;
        end
        if (w5_valid_reg && (w5_addr_reg == addr3))
        begin
            base = w5_sum_reg;
        end
        if (tag4_reg.valid && (w4_addr_reg == addr3))
        begin
            base = w4_sum_reg;
        end
        if (tag3.first)
        begin
            base = '0;
        end
        acc = ACC_W'(base) + ACC_W'(dot3);
        if (acc > ACC_MAX)
        begin
            sum_next = SUM_W'(ACC_MAX);
        end
        else if (acc < ACC_MIN)
        begin
            sum_next = SUM_W'(ACC_MIN);
        end
        else
        begin
            sum_next = SUM_W'(acc);
        end
    end

    // Memory port: read at accept, write when the item leaves stage three.
    always_ff @(posedge clk)
    begin
        if (adv && rd_tag.valid)
        begin
            rdata1_reg <= mem[rd_addr];
        end
        if (adv && tag3.valid)
        begin
            mem[addr3] <= sum_next;
        end
    end

    // Read data and write copies follow the pipeline.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rdata2_reg  <= rdata1_reg;
            rdata3_reg  <= rdata2_reg;
            w4_addr_reg <= addr3;
            w4_sum_reg  <= sum_next;
            w5_addr_reg <= w4_addr_reg;
            w5_sum_reg  <= w4_sum_reg;
            w6_addr_reg <= w5_addr_reg;
            w6_sum_reg  <= w5_sum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag4_reg     <= '0;
            w5_valid_reg <= 1'b0;
            w6_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            tag4_reg     <= tag3;
            w5_valid_reg <= tag4_reg.valid;
            w6_valid_reg <= w5_valid_reg;
        end
    end

    assign tag4_o = tag4_reg;
    assign sum4_o = w4_sum_reg;

    // The item in stage four made the latest write to its entry.
    a_last_write_held: assert property (@(posedge clk) disable iff (!rst_n)
        tag4_reg.valid |-> (mem[w4_addr_reg] == w4_sum_reg))
        else $error("stage four sum differs from the stored entry");

    // A stall holds the read data and the write copies.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(rdata3_reg) && $stable(w4_sum_reg) && $stable(w6_addr_reg)))
        else $error("partial-sum pipeline moved during a stall");

endmodule

`default_nettype wire

/* design/cvlr_act.sv */
// ----------------------------------------------------------------------------
// cvlr_act
// Leaky ReLU, requantisation multiply and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cvlr_act (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  cvlr_pkg::tag_t                      tag4,
    input  logic signed [cvlr_pkg::SUM_W-1:0]   sum4,
    input  logic [cvlr_pkg::LEAK_W-1:0]         leak,
    input  logic signed [cvlr_pkg::BIAS_W-1:0]  bias,
    input  logic [cvlr_pkg::MULT_W-1:0]         mult,
    output logic                                res_valid,
    output cvlr_pkg::res_t                      res_data
);

    localparam int SUM_W  = cvlr_pkg::SUM_W;
    localparam int LEAK_W = cvlr_pkg::LEAK_W;
    localparam int BYTE_W = cvlr_pkg::BYTE_W;
    localparam int LKP_W  = SUM_W + LEAK_W + 1;
    localparam int DIFF_W = SUM_W + 1;
    localparam int REQ_W  = DIFF_W + cvlr_pkg::MULT_W + 1;

    cvlr_pkg::tag_t          tag5_reg, tag6_reg;
    logic signed [LKP_W-1:0] lk_prod;
    logic signed [SUM_W-1:0] leaky_next, leaky5_reg;
    logic signed [DIFF_W-1:0] diff;
    logic signed [REQ_W-1:0] req_next, req6_reg;
    logic                    out_valid_reg;
    cvlr_pkg::res_t          out_reg;

    // Negative sums are scaled by the slope and shifted; the result always
    // lies within 16 bits, so no clamp follows it.
    always_comb
    begin
        lk_prod = LKP_W'(sum4) * LKP_W'($signed({1'b0, leak}));
        if (sum4[SUM_W-1])
        begin
            leaky_next = SUM_W'(lk_prod >>> cvlr_pkg::LEAK_SHIFT);
        end
        else
        begin
            leaky_next = sum4;
        end
    end

    // Offset removal and requantisation product.
    always_comb
    begin
        diff     = DIFF_W'(leaky5_reg) - DIFF_W'(bias);
        req_next = REQ_W'(diff) * REQ_W'($signed({1'b0, mult}));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            leaky5_reg           <= leaky_next;
            req6_reg             <= req_next;
            out_reg.out_filter   <= tag6_reg.filt;
            out_reg.out_position <= tag6_reg.pos;
            out_reg.out_byte     <= req6_reg[cvlr_pkg::REQ_SHIFT +: BYTE_W];
        end
    end

    // Only the last channel of a pixel gives a result beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag5_reg      <= '0;
            tag6_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            tag5_reg      <= tag4;
            tag6_reg      <= tag5_reg;
            out_valid_reg <= tag6_reg.valid && tag6_reg.last;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

    // A stall freezes the activation stages.
    a_act_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(tag5_reg) && $stable(tag6_reg) && $stable(req6_reg)))
        else $error("activation stages moved during a stall");

endmodule

`default_nettype wire

/* design/conv3x3_accum_leaky_requant.sv */
// ----------------------------------------------------------------------------
// conv3x3_accum_leaky_requant
// 3x3 convolution with per-pixel channel accumulation, leaky ReLU and int8
// requantisation.
// ----------------------------------------------------------------------------
// The block takes one window beat per clock cycle unless the output stalls. A
// result beat, for items on the last channel, leaves the output register once
// its window has passed the pipeline stages: window register, nine 8x8
// products, their sum, partial-sum accumulate and clamp, leaky multiply,
// requantisation multiply, output register. Partial sums live in a
// FILTERS*POSITIONS entry memory with one read port (used at accept) and one
// write port (used after accumulation); the three writes still in flight are
// forwarded, so channels of the same pixel may follow each other in adjacent
// cycles. The memory is not cleared: channel 0 of a pixel must come before its
// other channels. Items with an out-of-range filter, position or channel are
// taken and dropped. When a result waits and is not taken, the whole pipeline
// holds and window ready falls. Configuration writes are always taken and are
// meant for idle periods only.
`default_nettype none

module conv3x3_accum_leaky_requant #(
    parameter int FILTERS   = cvlr_pkg::FILTERS_DEF,
    parameter int POSITIONS = cvlr_pkg::POSITIONS_DEF,
    parameter int CHANNELS  = cvlr_pkg::CHANNELS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    cvlr_stream_if.sink   win,
    cvlr_stream_if.source res,
    cvlr_stream_if.sink   cfg
);

    localparam int WREG_W = cvlr_pkg::WREG_W;
    localparam int WREGS  = cvlr_pkg::WREGS;

    logic [WREG_W-1:0]                 weights_reg [WREGS];
    logic [cvlr_pkg::LEAK_W-1:0]       leak_reg;
    logic signed [cvlr_pkg::BIAS_W-1:0] bias_reg;
    logic [cvlr_pkg::MULT_W-1:0]       mult_reg;
    logic [cvlr_pkg::WFLAT_W-1:0]      weights_flat;

    logic                              adv;
    logic                              in_range;
    cvlr_pkg::tag_t                    in_tag;
    cvlr_pkg::tag_t                    tag3, tag4;
    logic signed [cvlr_pkg::DOT_W-1:0] dot3;
    logic signed [cvlr_pkg::SUM_W-1:0] sum4;
    logic                              res_valid;
    cvlr_pkg::res_t                    res_data;

    // Configuration registers.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < WREGS; r++)
            begin
                weights_reg[r] <= '0;
            end
            leak_reg <= cvlr_pkg::LEAK_RST;
            bias_reg <= cvlr_pkg::BIAS_RST;
            mult_reg <= cvlr_pkg::MULT_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.data.index)
                cvlr_pkg::REG_WEIGHTS_A:    weights_reg[0] <= cfg.data.value;
                cvlr_pkg::REG_WEIGHTS_B:    weights_reg[1] <= cfg.data.value;
                cvlr_pkg::REG_WEIGHTS_C:    weights_reg[2] <= cfg.data.value;
                cvlr_pkg::REG_WEIGHTS_D:    weights_reg[3] <= cfg.data.value;
                cvlr_pkg::REG_WEIGHTS_E:    weights_reg[4] <= cfg.data.value;
                cvlr_pkg::REG_LEAK_MULT:    leak_reg <= cfg.data.value[cvlr_pkg::LEAK_W-1:0];
                cvlr_pkg::REG_REQUANT_BIAS: bias_reg <= $signed(cfg.data.value[cvlr_pkg::BIAS_W-1:0]);
                cvlr_pkg::REG_REQUANT_MULT: mult_reg <= cfg.data.value[cvlr_pkg::MULT_W-1:0];
                default:                    ;
            endcase
        end
    end

    assign weights_flat = {weights_reg[4], weights_reg[3], weights_reg[2],
                           weights_reg[1], weights_reg[0]};

    // The pipeline moves whenever the output register is free or being read.
    assign adv       = !res_valid || res.ready;
    assign win.ready = adv;

    assign in_range = (int'(win.data.filter) < FILTERS)
                   && (int'(win.data.position) < POSITIONS)
                   && (int'(win.data.channel) < CHANNELS);

    always_comb
    begin
        in_tag.valid = win.valid && adv && in_range;
        in_tag.first = (win.data.channel == '0);
        in_tag.last  = (int'(win.data.channel) == CHANNELS - 1);
        in_tag.filt  = win.data.filter;
        in_tag.pos   = win.data.position;
    end

    cvlr_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .tag_i   (in_tag),
        .win_i   (win.data),
        .weights (weights_flat),
        .tag_o   (tag3),
        .dot_o   (dot3)
    );

    cvlr_psum #(
        .FILTERS   (FILTERS),
        .POSITIONS (POSITIONS)
    ) u_psum (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .rd_tag (in_tag),
        .tag3   (tag3),
        .dot3   (dot3),
        .tag4_o (tag4),
        .sum4_o (sum4)
    );

    cvlr_act u_act (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .tag4      (tag4),
        .sum4      (sum4),
        .leak      (leak_reg),
        .bias      (bias_reg),
        .mult      (mult_reg),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    assign res.valid = res_valid;
    assign res.data  = res_data;

    // A waiting result that is not taken stops new windows.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.ready) |-> !win.ready)
        else $error("window accepted while the result beat is stalled");

endmodule

`default_nettype wire
